// ----- src/adaptive_rank_factor_sgd_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the adaptive rank factor SGD engine
// Clocked implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_RANK_FACTOR_SGD_MACROS_SVH
`define ADAPTIVE_RANK_FACTOR_SGD_MACROS_SVH

// same-cycle implication
`define ARF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arf check failed");

// next-cycle implication
`define ARF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arf check failed");

`endif

// ----- src/arf_pkg.sv -----
// ---------------------------------------------------------------------------
// arf_pkg
// Shared constants, codes, types and helper functions of the factor engine.
// ---------------------------------------------------------------------------
package arf_pkg;

  localparam int MAX_USERS  = 4096;
  // both memories share one row width and depth
  localparam int MAX_ITEMS  = MAX_USERS;
  localparam int MAX_DIM    = 64;

  localparam int ROW_W      = $clog2(MAX_USERS);
  localparam int SLOT_W     = $clog2(MAX_DIM);
  localparam int FMEM_AW    = ROW_W + SLOT_W;
  localparam int FMEM_DEPTH = MAX_USERS * MAX_DIM;
  localparam int RANK_W     = 7;

  // shared multiplier operand and product widths
  localparam int MUL_AW = 35;
  localparam int MUL_BW = 33;
  localparam int PROD_W = 68;

  // function codes
  localparam logic [2:0] FN_TRAIN     = 3'd0;
  localparam logic [2:0] FN_ESTIMATE  = 3'd1;
  localparam logic [2:0] FN_LOAD_USER = 3'd2;
  localparam logic [2:0] FN_LOAD_ITEM = 3'd3;
  localparam logic [2:0] FN_READ_USER = 3'd4;
  localparam logic [2:0] FN_READ_ITEM = 3'd5;

  // register indexes
  localparam logic [2:0] REG_MEAN_COUNT    = 3'd0;
  localparam logic [2:0] REG_INV_STD_COUNT = 3'd1;
  localparam logic [2:0] REG_STEEPNESS     = 3'd2;
  localparam logic [2:0] REG_OFFSET        = 3'd3;
  localparam logic [2:0] REG_LEARN_RATE    = 3'd4;
  localparam logic [2:0] REG_USER_REG      = 3'd5;
  localparam logic [2:0] REG_ITEM_REG      = 3'd6;
  localparam logic [2:0] REG_FACTOR_DIM    = 3'd7;

  localparam logic [5:0] SIG_LAST = 6'd32;
  localparam logic signed [PROD_W-1:0] DIFF_LIMIT = PROD_W'(64'sd8589934592);
  localparam logic signed [PROD_W-1:0] ARG_LIMIT  = PROD_W'(64'sd524288);

  typedef struct packed {
    logic signed [MUL_AW-1:0] a;
    logic signed [MUL_BW-1:0] b;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sd2147483647);
    lo = -PROD_W'(64'sd2147483648);
    if (x > hi) return 32'sh7FFF_FFFF;
    else if (x < lo) return 32'sh8000_0000;
    else return x[31:0];
  endfunction

  // sigmoid samples at steps of 1/4, Q0.16
  function automatic logic [16:0] sig_val(input logic [5:0] i);
    case (i)
      6'd0:  return 17'd32768;
      6'd1:  return 17'd36843;
      6'd2:  return 17'd40793;
      6'd3:  return 17'd44511;
      6'd4:  return 17'd47911;
      6'd5:  return 17'd50941;
      6'd6:  return 17'd53581;
      6'd7:  return 17'd55834;
      6'd8:  return 17'd57724;
      6'd9:  return 17'd59287;
      6'd10: return 17'd60565;
      6'd11: return 17'd61598;
      6'd12: return 17'd62428;
      6'd13: return 17'd63090;
      6'd14: return 17'd63615;
      6'd15: return 17'd64030;
      6'd16: return 17'd64357;
      6'd17: return 17'd64614;
      6'd18: return 17'd64816;
      6'd19: return 17'd64974;
      6'd20: return 17'd65097;
      6'd21: return 17'd65194;
      6'd22: return 17'd65269;
      6'd23: return 17'd65328;
      6'd24: return 17'd65374;
      6'd25: return 17'd65410;
      6'd26: return 17'd65438;
      6'd27: return 17'd65459;
      6'd28: return 17'd65476;
      6'd29: return 17'd65489;
      6'd30: return 17'd65500;
      6'd31: return 17'd65508;
      default: return 17'd65514;
    endcase
  endfunction

endpackage

// ----- src/arf_mul.sv -----
// ---------------------------------------------------------------------------
// arf_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module arf_mul
  import arf_pkg::*;
(
  input  logic                     clk,
  input  mul_req_t                 req,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(req.a) * PROD_W'(req.b);
  end

endmodule

// ----- src/arf_fmem.sv -----
// ---------------------------------------------------------------------------
// arf_fmem
// Single-port factor memory, one word per row and slot, registered read.
// ---------------------------------------------------------------------------
module arf_fmem
  import arf_pkg::*;
(
  input  logic               clk,
  input  logic [FMEM_AW-1:0] addr,
  input  logic               we,
  input  logic [31:0]        wdata,
  output logic [31:0]        rdata
);

  logic [31:0] mem [FMEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/adaptive_rank_factor_sgd.sv -----
// ---------------------------------------------------------------------------
// adaptive_rank_factor_sgd
// Adaptive-rank matrix factorization SGD engine on one shared multiplier.
// ---------------------------------------------------------------------------
// Sequence: train and estimate pick a rank r (1..64) and run a dot pass over r factors;
//   train then runs a user and an item update step per factor, all on the shared multiplier.
// Throughput: one beat at a time; busy stays high until the result strobe.
// Result: done is high for one cycle with the result; the receiver cannot stall.
// Reset: synchronous rst restores state and config registers; datapath and memories are left as is.
// ---------------------------------------------------------------------------
module adaptive_rank_factor_sgd
  import arf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func,
  input  logic [11:0]        user_index,
  input  logic [11:0]        item_index,
  input  logic signed [31:0] rating,
  input  logic [15:0]        user_count,
  input  logic [15:0]        item_count,
  input  logic [5:0]         factor_slot,
  input  logic signed [31:0] factor_value,
  // result side
  output logic               done,
  output logic signed [31:0] estimate,
  output logic [6:0]         rank_used,
  output logic signed [31:0] error,
  output logic signed [31:0] read_value,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Sequencer: rank pick, dot pass, then on train per factor a user and an item step; plus load and read states
  typedef enum logic [25:0] {
    S_IDLE = 26'd1 << 0,
    S_RK0  = 26'd1 << 1,
    S_RK1  = 26'd1 << 2,
    S_RK2  = 26'd1 << 3,
    S_RK3  = 26'd1 << 4,
    S_RK4  = 26'd1 << 5,
    S_RK5  = 26'd1 << 6,
    S_RK6  = 26'd1 << 7,
    S_DRD  = 26'd1 << 8,
    S_DMUL = 26'd1 << 9,
    S_DACC = 26'd1 << 10,
    S_EST  = 26'd1 << 11,
    S_ERR  = 26'd1 << 12,
    S_URD  = 26'd1 << 13,
    S_ULAT = 26'd1 << 14,
    S_G0   = 26'd1 << 15,
    S_G1   = 26'd1 << 16,
    S_G2   = 26'd1 << 17,
    S_G3   = 26'd1 << 18,
    S_G4   = 26'd1 << 19,
    S_G5   = 26'd1 << 20,
    S_UWR  = 26'd1 << 21,
    S_LOAD = 26'd1 << 22,
    S_MRD  = 26'd1 << 23,
    S_MOUT = 26'd1 << 24,
    S_DONE = 26'd1 << 25
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [15:0]        mean_count;
  logic [31:0]        inv_std_count;
  logic signed [15:0] steepness;
  logic signed [15:0] offset;
  logic [15:0]        learn_rate;
  logic [15:0]        user_reg;
  logic [15:0]        item_reg;
  logic [6:0]         factor_dim;

  // captured command
  logic [2:0]         func_r;
  logic [ROW_W-1:0]   urow;
  logic [ROW_W-1:0]   irow;
  logic signed [31:0] rating_r;
  logic [15:0]        ucnt;
  logic [15:0]        icnt;
  logic [5:0]         slot_r;
  logic signed [31:0] fval_r;
  logic [6:0]         dim_r;

  // working registers
  logic                     neg;
  logic [5:0]               idx;
  logic [13:0]              frac;
  logic [16:0]              s_r;
  logic [RANK_W-1:0]        rank;
  logic [RANK_W-1:0]        k;
  logic signed [55:0]       acc;
  logic                     side;
  logic signed [31:0]       uo, io, nu, ni;
  logic signed [48:0]       g1, gr;
  logic signed [PROD_W-1:0] ph;

  mul_req_t                 mreq;
  logic signed [PROD_W-1:0] prod;

  logic [FMEM_AW-1:0] maddr_u, maddr_i;
  logic               we_u, we_i;
  logic [31:0]        wd_u, wd_i, rd_u, rd_i;

  logic cfg_wr;
  logic accept;
  logic slot_ok;
  logic last_k;

  // combinational helpers
  logic [15:0]              cmin;
  logic signed [16:0]       cdiff;
  logic signed [PROD_W-1:0] tw, argw;
  logic [19:0]              aabs;
  logic [16:0]              sdiff, sv, v;
  logic [8:0]               rw;
  logic signed [31:0]       self_v, other_v;
  logic [15:0]              regw;
  logic signed [PROD_W-1:0] dsum, newsum;
  logic signed [31:0]       newv;
  logic [6:0]               dim_in;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign accept = start & ~busy;

  assign slot_ok = ({3'b0, slot_r} < 9'(MAX_DIM));
  assign last_k  = ((k + 7'd1) == rank);

  assign dim_in = (factor_dim == 7'd0) ? 7'd1 :
                  ({2'b0, factor_dim} > 9'(MAX_DIM)) ? 7'(MAX_DIM) : factor_dim;

  // config read-back
  always_comb begin
    case (paddr[4:2])
      REG_MEAN_COUNT:    prdata = {16'b0, mean_count};
      REG_INV_STD_COUNT: prdata = inv_std_count;
      REG_STEEPNESS:     prdata = {{16{steepness[15]}}, steepness};
      REG_OFFSET:        prdata = {{16{offset[15]}}, offset};
      REG_LEARN_RATE:    prdata = {16'b0, learn_rate};
      REG_USER_REG:      prdata = {16'b0, user_reg};
      REG_ITEM_REG:      prdata = {16'b0, item_reg};
      REG_FACTOR_DIM:    prdata = {25'b0, factor_dim};
      default:           prdata = 32'b0;
    endcase
  end

  // rank arithmetic helpers
  always_comb begin
    cmin  = (ucnt < icnt) ? ucnt : icnt;
    cdiff = signed'({1'b0, cmin}) - signed'({1'b0, mean_count});
    tw    = prod - PROD_W'(signed'({offset, 8'b0}));
    if (tw > DIFF_LIMIT) tw = DIFF_LIMIT;
    if (tw < -DIFF_LIMIT) tw = -DIFF_LIMIT;
    argw  = prod >>> 8;
    if (argw > ARG_LIMIT) argw = ARG_LIMIT;
    if (argw < -ARG_LIMIT) argw = -ARG_LIMIT;
    aabs  = argw[PROD_W-1] ? 20'(-argw) : 20'(argw);
    sdiff = (idx < SIG_LAST) ? (sig_val(idx + 6'd1) - sig_val(idx)) : 17'd0;
    v     = sig_val(idx) + prod[30:14];
    sv    = neg ? (17'd65536 - v) : v;
    rw    = 9'((prod[24:0] + 25'd65535) >> 16);
  end

  // update step helpers: side 0 is the user element, side 1 the item element
  always_comb begin
    self_v  = side ? io : uo;
    other_v = side ? nu : io;
    regw    = side ? item_reg : user_reg;
    dsum    = (ph <<< 24) + prod;
    newsum  = PROD_W'(self_v) + (dsum >>> 15);
    newv    = sat32(newsum);
  end

  // multiplier operand selection
  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    case (state)
      S_RK0: begin
        mreq.a = MUL_AW'(cdiff);
        mreq.b = {1'b0, inv_std_count};
      end
      S_RK1: begin
        mreq.a = MUL_AW'(tw);
        mreq.b = MUL_BW'(steepness);
      end
      S_RK3: begin
        mreq.a = {18'b0, sdiff};
        mreq.b = {19'b0, frac};
      end
      S_RK5: begin
        mreq.a = {18'b0, s_r};
        mreq.b = {26'b0, dim_r};
      end
      S_DMUL: begin
        mreq.a = MUL_AW'(signed'(rd_u));
        mreq.b = MUL_BW'(signed'(rd_i));
      end
      S_G0: begin
        mreq.a = MUL_AW'(error);
        mreq.b = MUL_BW'(other_v);
      end
      S_G1: begin
        mreq.a = {19'b0, regw};
        mreq.b = MUL_BW'(self_v);
      end
      S_G3: begin
        mreq.a = MUL_AW'(gr >>> 24);
        mreq.b = {17'b0, learn_rate};
      end
      S_G4: begin
        mreq.a = {11'b0, gr[23:0]};
        mreq.b = {17'b0, learn_rate};
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  // memory ports: loads and reads address the slot, the passes address k
  always_comb begin
    logic [SLOT_W-1:0] col;
    col     = (state == S_LOAD || state == S_MRD) ? slot_r[SLOT_W-1:0] : k[SLOT_W-1:0];
    maddr_u = {urow, col};
    maddr_i = {irow, col};
    we_u    = ((state == S_LOAD) && (func_r == FN_LOAD_USER) && slot_ok) ||
              (state == S_UWR);
    we_i    = ((state == S_LOAD) && (func_r == FN_LOAD_ITEM) && slot_ok) ||
              (state == S_UWR);
    wd_u    = (state == S_UWR) ? nu : fval_r;
    wd_i    = (state == S_UWR) ? ni : fval_r;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FN_TRAIN, FN_ESTIMATE:       state_next = S_RK0;
            FN_LOAD_USER, FN_LOAD_ITEM:  state_next = S_LOAD;
            FN_READ_USER, FN_READ_ITEM:  state_next = S_MRD;
            default:                     state_next = S_DONE;
          endcase
        end
      end
      S_RK0:  state_next = S_RK1;
      S_RK1:  state_next = S_RK2;
      S_RK2:  state_next = S_RK3;
      S_RK3:  state_next = S_RK4;
      S_RK4:  state_next = S_RK5;
      S_RK5:  state_next = S_RK6;
      S_RK6:  state_next = S_DRD;
      S_DRD:  state_next = S_DMUL;
      S_DMUL: state_next = S_DACC;
      S_DACC: state_next = last_k ? S_EST : S_DRD;
      S_EST:  state_next = S_ERR;
      S_ERR:  state_next = (func_r == FN_TRAIN) ? S_URD : S_DONE;
      S_URD:  state_next = S_ULAT;
      S_ULAT: state_next = S_G0;
      S_G0:   state_next = S_G1;
      S_G1:   state_next = S_G2;
      S_G2:   state_next = S_G3;
      S_G3:   state_next = S_G4;
      S_G4:   state_next = S_G5;
      S_G5:   state_next = side ? S_UWR : S_G0;
      S_UWR:  state_next = last_k ? S_DONE : S_URD;
      S_LOAD: state_next = S_DONE;
      S_MRD:  state_next = S_MOUT;
      S_MOUT: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      k             <= '0;
      side          <= 1'b0;
      mean_count    <= 16'd0;
      inv_std_count <= 32'd65536;
      steepness     <= 16'sd256;
      offset        <= 16'sd0;
      learn_rate    <= 16'd655;
      user_reg      <= 16'd655;
      item_reg      <= 16'd655;
      factor_dim    <= 7'd64;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_MEAN_COUNT:    mean_count    <= pwdata[15:0];
          REG_INV_STD_COUNT: inv_std_count <= pwdata;
          REG_STEEPNESS:     steepness     <= signed'(pwdata[15:0]);
          REG_OFFSET:        offset        <= signed'(pwdata[15:0]);
          REG_LEARN_RATE:    learn_rate    <= pwdata[15:0];
          REG_USER_REG:      user_reg      <= pwdata[15:0];
          REG_ITEM_REG:      item_reg      <= pwdata[15:0];
          REG_FACTOR_DIM:    factor_dim    <= pwdata[6:0];
          default: ;
        endcase
      end
      case (state)
        S_RK6:  k <= '0;
        S_DACC: k <= last_k ? '0 : k + 7'd1;
        S_ULAT: side <= 1'b0;
        S_G5:   side <= ~side;
        S_UWR:  k <= k + 7'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          func_r     <= func;
          urow       <= user_index[ROW_W-1:0];
          irow       <= item_index[ROW_W-1:0];
          rating_r   <= rating;
          ucnt       <= user_count;
          icnt       <= item_count;
          slot_r     <= factor_slot;
          fval_r     <= factor_value;
          dim_r      <= dim_in;
          estimate   <= '0;
          rank_used  <= '0;
          error      <= '0;
          read_value <= '0;
        end
      end
      S_RK2: begin
        neg  <= argw[PROD_W-1];
        idx  <= aabs[19:14];
        frac <= aabs[13:0];
      end
      S_RK4: s_r <= sv;
      S_RK6: begin
        // clamp the rank into 1..dim
        if (rw == 9'd0) rank <= 7'd1;
        else if (rw > {2'b0, dim_r}) rank <= dim_r;
        else rank <= rw[6:0];
        acc <= '0;
      end
      S_DACC: acc <= acc + 56'(prod >>> 16);
      S_EST: begin
        estimate  <= sat32(PROD_W'(acc));
        rank_used <= rank;
      end
      S_ERR:  error <= sat32(PROD_W'(rating_r) - PROD_W'(estimate));
      S_ULAT: begin
        uo <= rd_u;
        io <= rd_i;
      end
      S_G1: g1 <= 49'(prod >>> 16);
      S_G2: gr <= g1 - 49'(prod >>> 16);
      S_G4: ph <= prod;
      S_G5: begin
        if (side) ni <= newv;
        else nu <= newv;
      end
      S_MOUT: read_value <= slot_ok ? ((func_r == FN_READ_USER) ? rd_u : rd_i) : 32'sd0;
      default: ;
    endcase
  end

  arf_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  arf_fmem u_user_mem (
    .clk   (clk),
    .addr  (maddr_u),
    .we    (we_u),
    .wdata (wd_u),
    .rdata (rd_u)
  );

  arf_fmem u_item_mem (
    .clk   (clk),
    .addr  (maddr_i),
    .we    (we_i),
    .wdata (wd_i),
    .rdata (rd_i)
  );

endmodule

// ----- src/arf_chk.sv -----
// ---------------------------------------------------------------------------
// arf_chk
// Port-level checks of the command and result handshake and of the rank range, bound to the top.
// ---------------------------------------------------------------------------
`include "adaptive_rank_factor_sgd_macros.svh"

module arf_chk
  import arf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [6:0] rank_used
);

  `ARF_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ARF_ASSERT_NOW(a_done_busy, clk, rst, done, busy)
  `ARF_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy)
  `ARF_ASSERT_NOW(a_rank_range, clk, rst, done, rank_used <= 7'(MAX_DIM))

endmodule

bind adaptive_rank_factor_sgd arf_chk u_arf_chk (.*);

// ----- tb/arf_scoreboard.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// arf_scoreboard
// Watches the command, result and register ports of the factor engine, keeps
// its own copy of the factor rows and registers, predicts every result and
// compares each result beat field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module arf_scoreboard
  import arf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         func,
  input  logic [11:0]        user_index,
  input  logic [11:0]        item_index,
  input  logic signed [31:0] rating,
  input  logic [15:0]        user_count,
  input  logic [15:0]        item_count,
  input  logic [5:0]         factor_slot,
  input  logic signed [31:0] factor_value,
  input  logic               done,
  input  logic signed [31:0] estimate,
  input  logic [6:0]         rank_used,
  input  logic signed [31:0] error,
  input  logic signed [31:0] read_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct {
    logic signed [31:0] est;
    logic [6:0]         rank;
    logic signed [31:0] err;
    logic signed [31:0] rd;
  } outcome_t;

  typedef logic signed [95:0] wide_t;

  localparam int unsigned SIGMOID_TAB [33] = '{
    32768, 36843, 40793, 44511, 47911, 50941, 53581, 55834,
    57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
    64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
    65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508,
    65514};

  outcome_t           pending_q[$];
  logic signed [31:0] user_rows[int];
  logic signed [31:0] item_rows[int];

  logic [15:0]        mean_cnt = 16'd0;
  logic [31:0]        inv_std  = 32'd65536;
  logic signed [15:0] steep    = 16'sd256;
  logic signed [15:0] centre   = 16'sd0;
  logic [15:0]        lrate    = 16'd655;
  logic [15:0]        ureg     = 16'd655;
  logic [15:0]        ireg     = 16'd655;
  logic [6:0]         dim_cfg  = 7'd64;

  assign outstanding = pending_q.size();

  function automatic logic signed [31:0] clip32(input wide_t x);
    if (x > wide_t'(64'sd2147483647)) return 32'sh7FFF_FFFF;
    if (x < -wide_t'(64'sd2147483648)) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [6:0] rank_for(input logic [15:0] uc, input logic [15:0] ic,
                                          input int dim);
    wide_t c, t, arg, mag, r;
    int unsigned idx, frac, v;
    c = (uc < ic) ? uc : ic;
    t = (c - wide_t'(mean_cnt)) * wide_t'(inv_std) - wide_t'(centre) * 256;
    if (t > (wide_t'(1) <<< 33)) t = wide_t'(1) <<< 33;
    if (t < -(wide_t'(1) <<< 33)) t = -(wide_t'(1) <<< 33);
    arg = (wide_t'(steep) * t) >>> 8;
    if (arg > wide_t'(524288)) arg = 524288;
    if (arg < -wide_t'(524288)) arg = -524288;
    mag  = (arg < 0) ? -arg : arg;
    idx  = int'(mag >>> 14);
    frac = int'(mag & 16'h3FFF);
    if (idx >= 32) v = SIGMOID_TAB[32];
    else v = SIGMOID_TAB[idx] + (((SIGMOID_TAB[idx+1] - SIGMOID_TAB[idx]) * frac) >> 14);
    if (arg < 0) v = 65536 - v;
    r = (wide_t'(v) * dim + 65535) >>> 16;
    if (r < 1) r = 1;
    if (r > dim) r = dim;
    return r[6:0];
  endfunction

  // one gradient step of a factor element
  function automatic logic signed [31:0] nudge(input logic signed [31:0] self,
                                               input logic signed [31:0] err,
                                               input logic signed [31:0] other,
                                               input logic [15:0] weight);
    wide_t g;
    g = ((wide_t'(err) * wide_t'(other)) >>> 16) - ((wide_t'(weight) * wide_t'(self)) >>> 16);
    return clip32(wide_t'(self) + ((g * wide_t'(lrate)) >>> 15));
  endfunction

  function automatic outcome_t predict_result();
    outcome_t o;
    wide_t acc;
    int dim, ubase, ibase;
    logic signed [31:0] old_item, new_user;
    o = '{default: '0};
    ubase = int'(user_index) * MAX_DIM;
    ibase = int'(item_index) * MAX_DIM;
    case (func)
      FN_TRAIN, FN_ESTIMATE: begin
        dim = (dim_cfg < 1) ? 1 : (dim_cfg > MAX_DIM) ? MAX_DIM : int'(dim_cfg);
        o.rank = rank_for(user_count, item_count, dim);
        acc = 0;
        for (int k = 0; k < o.rank; k++)
          acc += (wide_t'(user_rows[ubase+k]) * wide_t'(item_rows[ibase+k])) >>> 16;
        o.est = clip32(acc);
        o.err = clip32(wide_t'(rating) - wide_t'(o.est));
        if (func == FN_TRAIN) begin
          for (int k = 0; k < o.rank; k++) begin
            old_item = item_rows[ibase+k];
            new_user = nudge(user_rows[ubase+k], o.err, old_item, ureg);
            user_rows[ubase+k] = new_user;
            item_rows[ibase+k] = nudge(old_item, o.err, new_user, ireg);
          end
        end
      end
      FN_LOAD_USER: user_rows[ubase+factor_slot] = factor_value;
      FN_LOAD_ITEM: item_rows[ibase+factor_slot] = factor_value;
      FN_READ_USER: o.rd = user_rows[ubase+factor_slot];
      FN_READ_ITEM: o.rd = item_rows[ibase+factor_slot];
      default: ;
    endcase
    return o;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      // retire the result beat before taking a new command on the same edge
      if (done) begin
        if (pending_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          want = pending_q.pop_front();
          if (want.est !== estimate || want.rank !== rank_used ||
              want.err !== error || want.rd !== read_value) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch at %0t: exp est %0d rank %0d err %0d rd %0d, got %0d %0d %0d %0d",
                       $realtime, want.est, want.rank, want.err, want.rd,
                       estimate, rank_used, error, read_value);
          end
        end
      end
      if (start && !busy) pending_q.insert(pending_q.size(), predict_result());
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MEAN_COUNT:    mean_cnt = pwdata[15:0];
          REG_INV_STD_COUNT: inv_std  = pwdata;
          REG_STEEPNESS:     steep    = pwdata[15:0];
          REG_OFFSET:        centre   = pwdata[15:0];
          REG_LEARN_RATE:    lrate    = pwdata[15:0];
          REG_USER_REG:      ureg     = pwdata[15:0];
          REG_ITEM_REG:      ireg     = pwdata[15:0];
          REG_FACTOR_DIM:    dim_cfg  = pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/tb_adaptive_rank_factor_sgd.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_adaptive_rank_factor_sgd
// Drives the factor engine through register settings and command beats:
// loads a pool of rows, runs directed extremes, then random train, estimate,
// load, read and unused commands; the scoreboard checks every result beat.
// ---------------------------------------------------------------------------
module tb_adaptive_rank_factor_sgd;
  import arf_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func = FN_TRAIN;
  logic [11:0] user_index = '0, item_index = '0;
  logic signed [31:0] rating = '0;
  logic [15:0] user_count = '0, item_count = '0;
  logic [5:0] factor_slot = '0;
  logic signed [31:0] factor_value = '0;
  logic done;
  logic signed [31:0] estimate, error, read_value;
  logic [6:0] rank_used;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, outstanding;
  int cycles = 0;
  bit no_gaps = 1'b0;

  // rows that are fully loaded before use, so nothing unwritten is ever read
  localparam logic [11:0] ROWS [4] = '{12'd0, 12'd4095, 12'd1365, 12'd2730};

  always #5 clk = ~clk;

  adaptive_rank_factor_sgd dut (.*);

  arf_scoreboard checker_i (.*);

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // write one register: setup phase, then access phase
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // hold the command until the engine takes it, then drop start
  task automatic send_beat(input logic [2:0] f, input logic [11:0] u, input logic [11:0] i,
                           input logic signed [31:0] r, input logic [15:0] uc,
                           input logic [15:0] ic, input logic [5:0] s,
                           input logic signed [31:0] v);
    int gap;
    if (!no_gaps && $urandom_range(0, 99) < 34) begin
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    func = f; user_index = u; item_index = i; rating = r;
    user_count = uc; item_count = ic; factor_slot = s; factor_value = v;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    func = 3'($urandom); factor_value = $urandom;
  endtask

  // wait for the engine to drain before touching registers
  task automatic settle();
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] mean, input logic [31:0] inv,
                          input logic [15:0] stp, input logic [15:0] off,
                          input logic [15:0] lr, input logic [15:0] ur,
                          input logic [15:0] ir, input logic [6:0] dim);
    settle();
    reg_write(REG_MEAN_COUNT, mean);
    reg_write(REG_INV_STD_COUNT, inv);
    reg_write(REG_STEEPNESS, stp);
    reg_write(REG_OFFSET, off);
    reg_write(REG_LEARN_RATE, lr);
    reg_write(REG_USER_REG, ur);
    reg_write(REG_ITEM_REG, ir);
    reg_write(REG_FACTOR_DIM, dim);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    return $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200));
  endfunction

  task automatic random_beat();
    int kind;
    logic [11:0] u, i;
    kind = $urandom_range(0, 99);
    u = ROWS[$urandom_range(0, 3)];
    i = ROWS[$urandom_range(0, 3)];
    if (kind < 50)
      send_beat(FN_TRAIN, u, i, pick_value(), pick_count(), pick_count(), 6'($urandom), $urandom);
    else if (kind < 65)
      send_beat(FN_ESTIMATE, u, i, pick_value(), pick_count(), pick_count(), 6'($urandom),
                $urandom);
    else if (kind < 75)
      send_beat($urandom_range(0, 1) ? FN_LOAD_USER : FN_LOAD_ITEM, u, i, $urandom,
                16'($urandom), 16'($urandom), 6'($urandom), pick_value());
    else if (kind < 95)
      send_beat($urandom_range(0, 1) ? FN_READ_USER : FN_READ_ITEM, u, i, $urandom,
                16'($urandom), 16'($urandom), 6'($urandom), $urandom);
    else
      // unused codes: anything goes, rows untouched
      send_beat(3'($urandom_range(6, 7)), 12'($urandom), 12'($urandom), $urandom,
                16'($urandom), 16'($urandom), 6'($urandom), $urandom);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the row pool; no gaps to keep this quick
    no_gaps = 1'b1;
    for (int r = 0; r < 4; r++)
      for (int k = 0; k < MAX_DIM; k++) begin
        send_beat(FN_LOAD_USER, ROWS[r], '0, '0, '0, '0, 6'(k), pick_value());
        send_beat(FN_LOAD_ITEM, '0, ROWS[r], '0, '0, '0, 6'(k), pick_value());
      end
    no_gaps = 1'b0;

    // directed: extremes of fields and each function under reset settings
    send_beat(FN_ESTIMATE, 12'd0, 12'd4095, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, '0, '0);
    send_beat(FN_TRAIN, 12'd4095, 12'd0, 32'sh8000_0000, 16'd0, 16'hFFFF, '0, '0);
    send_beat(FN_TRAIN, 12'd0, 12'd0, 32'sh7FFF_FFFF, 16'hFFFF, 16'd0, '0, '0);
    send_beat(FN_LOAD_USER, 12'd1365, '0, '0, '0, '0, 6'd63, 32'sh7FFF_FFFF);
    send_beat(FN_LOAD_ITEM, '0, 12'd2730, '0, '0, '0, 6'd0, 32'sh8000_0000);
    send_beat(FN_READ_USER, 12'd1365, '0, '0, '0, '0, 6'd63, '0);
    send_beat(FN_READ_ITEM, '0, 12'd2730, '0, '0, '0, 6'd0, '0);
    send_beat(3'd6, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 6'h3F, 32'hFFFF_FFFF);
    send_beat(3'd7, '0, '0, '0, '0, '0, '0, '0);

    // saturating learning at dimension 0 (as 1); then zero rates at 127 (as 64)
    set_regs(16'hFFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd0);
    send_beat(FN_TRAIN, 12'd2730, 12'd1365, 32'sh7FFF_FFFF, 16'd5, 16'd9, '0, '0);
    send_beat(FN_ESTIMATE, 12'd0, 12'd0, 32'sh8000_0000, 16'hFFFF, 16'hFFFF, '0, '0);
    set_regs(16'd0, 32'd0, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0, 7'd127);
    send_beat(FN_TRAIN, 12'd4095, 12'd4095, 32'sh0001_0000, 16'd3, 16'd3, '0, '0);
    send_beat(FN_ESTIMATE, 12'd1365, 12'd0, 32'sh0000_0000, 16'd100, 16'd1, '0, '0);

    // random phases over a spread of settings; long gap-free stretch in the third
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(16'd50, 32'd4096, 16'd256, 16'd0, 16'd655, 16'd655, 16'd655, 7'd8);
        1: set_regs(16'd100, 32'd65536, 16'd512, 16'hFF00, 16'd6553, 16'd100, 16'd3000,
                    7'd1);
        2: set_regs(16'd20, 32'd2000, 16'hFE00, 16'd128, 16'd300, 16'd0, 16'hFFFF, 7'd16);
        3: set_regs(16'hFFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 7'd64);
        4: set_regs(16'($urandom), $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 7'($urandom_range(0, 24)));
        default: set_regs(16'd30, 32'd20000, 16'd1024, 16'd64, 16'd1000, 16'd655,
                          16'd655, 7'd5);
      endcase
      no_gaps = (ph == 2);
      repeat (96) random_beat();
    end
    no_gaps = 1'b0;

    // drain, then allow the engine time to go quiet
    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
